@@ design/sap_pkg.sv @@
// Shared types, widths and codes for the shelf atlas packer.
// Used by sap_ctrl, sap_dp and the top level; depends on nothing.
`default_nettype none

package sap_pkg;

    localparam int MAX_SHELVES = 64;
    localparam int IDX_W       = $clog2(MAX_SHELVES);
    localparam int CNT_W       = $clog2(MAX_SHELVES + 1);

    localparam int RECT_W      = 14;
    localparam int COORD_W     = 15;
    localparam int TOP_CFG_W   = 8;
    localparam int CFG_DATA_W  = 15;
    localparam int CFG_IDX_W   = 1;

    localparam logic [COORD_W-1:0]   ATLAS_START    = 15'd128;
    localparam logic [COORD_W-1:0]   MAX_SIZE_RESET = 15'd4096;
    localparam logic [TOP_CFG_W-1:0] FIRST_TOP_RESET = 8'd3;

    // h / 10 == (h * 52429) >> 19 for every 14-bit h.
    localparam int DIV10_MUL_W = 16;
    localparam logic [DIV10_MUL_W-1:0] DIV10_MUL = 16'd52429;
    localparam int DIV10_SHIFT  = 19;
    localparam int DIV10_PROD_W = RECT_W + DIV10_MUL_W;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SIZE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_TOP = 1'b1;

    typedef enum logic [1:0] {
        STATUS_PLACED     = 2'd0,
        STATUS_NO_GROW    = 2'd1,
        STATUS_TABLE_FULL = 2'd2
    } status_t;

    typedef struct packed {
        logic [COORD_W-1:0] top;
        logic [COORD_W-1:0] height;
        logic [COORD_W-1:0] fill;
    } shelf_entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_GROW,
        ST_EMIT
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_SCAN,
        OP_PLACE,
        OP_FULL,
        OP_GROW_INIT,
        OP_DOUBLE,
        OP_NEW_ROW,
        OP_FAIL,
        OP_EMIT
    } op_t;

    typedef struct packed {
        logic in_ready;
        op_t  op;
    } sap_cmd_t;

    typedef struct packed {
        logic scan_done;
        logic found;
        logic table_full;
        logic grow_need;
        logic grow_can;
        logic out_free;
    } sap_status_t;

endpackage

`default_nettype wire

@@ design/sap_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; holds the shelf table of the packer.
`default_nettype none

module sap_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ design/sap_ctrl.sv @@
// Controller state machine of the shelf atlas packer.
// Depends on sap_pkg; drives the datapath with one operation per cycle.
`default_nettype none

module sap_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    input  sap_pkg::sap_status_t      status,
    output sap_pkg::sap_cmd_t         cmd
);
    import sap_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_SCAN;
            end
            ST_SCAN: begin
                if (status.scan_done) state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (status.found || status.table_full) state_next = ST_EMIT;
                else state_next = ST_GROW;
            end
            ST_GROW: begin
                if (!status.grow_need || !status.grow_can) state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (status.out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd.in_ready = 1'b0;
        cmd.op       = OP_NONE;
        case (state_reg)
            ST_IDLE: begin
                cmd.in_ready = 1'b1;
                if (s_tvalid) cmd.op = OP_LOAD;
            end
            ST_SCAN: begin
                cmd.op = OP_SCAN;
            end
            ST_DECIDE: begin
                if (status.found) cmd.op = OP_PLACE;
                else if (status.table_full) cmd.op = OP_FULL;
                else cmd.op = OP_GROW_INIT;
            end
            ST_GROW: begin
                if (!status.grow_need) cmd.op = OP_NEW_ROW;
                else if (status.grow_can) cmd.op = OP_DOUBLE;
                else cmd.op = OP_FAIL;
            end
            ST_EMIT: begin
                if (status.out_free) cmd.op = OP_EMIT;
            end
            default: begin
                cmd.op = OP_NONE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ design/sap_dp.sv @@
// Datapath of the shelf atlas packer: shelf table RAM, row scan, atlas growth,
// configuration registers and output register. Depends on sap_pkg and sap_ram.
`default_nettype none

module sap_dp (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  sap_pkg::sap_cmd_t                    cmd,
    output sap_pkg::sap_status_t                 status,
    input  wire logic [sap_pkg::RECT_W-1:0]      in_w,
    input  wire logic [sap_pkg::RECT_W-1:0]      in_h,
    input  wire logic                            cfg_we,
    input  wire logic [sap_pkg::CFG_IDX_W-1:0]   cfg_idx,
    input  wire logic [sap_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  wire logic                            out_ready,
    output logic                                 out_valid,
    output logic      [sap_pkg::RECT_W-1:0]      out_x,
    output logic      [sap_pkg::COORD_W-1:0]     out_y,
    output sap_pkg::status_t                     out_status,
    output logic      [sap_pkg::COORD_W-1:0]     out_aw,
    output logic      [sap_pkg::COORD_W-1:0]     out_ah
);
    import sap_pkg::*;

    // Configuration and persistent state.
    logic [COORD_W-1:0]   max_size_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [COORD_W-1:0]   next_top_reg;
    logic [COORD_W-1:0]   atlas_w_reg;
    logic [COORD_W-1:0]   atlas_h_reg;

    // Request and scan state.
    logic [RECT_W-1:0]       req_w_reg;
    logic [RECT_W-1:0]       req_h_reg;
    logic [DIV10_PROD_W-1:0] prod_reg;
    logic [COORD_W-1:0]      row_h_reg;
    logic [CNT_W-1:0]        scan_idx_reg;
    logic                    rd_vld_reg;
    logic [IDX_W-1:0]        rd_idx_reg;
    logic                    found_reg;
    logic [IDX_W-1:0]        best_idx_reg;
    logic [COORD_W-1:0]      best_h_reg;
    logic [COORD_W-1:0]      best_top_reg;
    logic [COORD_W-1:0]      best_fill_reg;
    logic [COORD_W-1:0]      grow_w_reg;
    logic [COORD_W-1:0]      grow_h_reg;

    // Result waiting for the output register.
    logic [RECT_W-1:0]  res_x_reg;
    logic [COORD_W-1:0] res_y_reg;
    status_t            res_status_reg;
    logic [COORD_W-1:0] res_aw_reg;
    logic [COORD_W-1:0] res_ah_reg;

    logic               out_valid_reg;
    logic [RECT_W-1:0]  out_x_reg;
    logic [COORD_W-1:0] out_y_reg;
    status_t            out_status_reg;
    logic [COORD_W-1:0] out_aw_reg;
    logic [COORD_W-1:0] out_ah_reg;

    shelf_entry_t     rd_entry;
    shelf_entry_t     wr_entry;
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;

    logic [17:0]        h_x10;
    logic [17:0]        rh_x7;
    logic [COORD_W:0]   fill_sum;
    logic               candidate;
    logic [COORD_W-1:0] row_h_calc;
    logic [COORD_W:0]   row_end;
    logic               out_free;

    sap_ram #(
        .WIDTH ($bits(shelf_entry_t)),
        .DEPTH (MAX_SHELVES)
    ) u_shelf_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (wr_entry),
        .raddr (scan_idx_reg[IDX_W-1:0]),
        .rdata (rd_entry)
    );

    // Row test on the entry that the RAM returned this cycle.
    always_comb begin
        h_x10     = 18'(req_h_reg) * 18'd10;
        rh_x7     = 18'(rd_entry.height) * 18'd7;
        fill_sum  = (COORD_W+1)'(rd_entry.fill) + (COORD_W+1)'(req_w_reg);
        candidate = rd_vld_reg
                    && (h_x10 >= rh_x7)
                    && ((COORD_W)'(req_h_reg) <= rd_entry.height)
                    && (fill_sum <= (COORD_W+1)'(atlas_w_reg))
                    && (!found_reg || (rd_entry.height <= best_h_reg));
    end

    assign row_h_calc = (COORD_W)'(req_h_reg)
                        + (COORD_W)'(prod_reg[DIV10_PROD_W-1:DIV10_SHIFT]);
    assign row_end    = (COORD_W+1)'(next_top_reg) + (COORD_W+1)'(row_h_reg);
    assign out_free   = !out_valid_reg || out_ready;

    always_comb begin
        status.scan_done  = (scan_idx_reg == count_reg) && !rd_vld_reg;
        status.found      = found_reg;
        status.table_full = (count_reg == CNT_W'(MAX_SHELVES));
        status.grow_need  = (row_end >= (COORD_W+1)'(grow_h_reg))
                            || ((COORD_W)'(req_w_reg) >= grow_w_reg);
        status.grow_can   = ({grow_w_reg, 1'b0} <= (COORD_W+1)'(max_size_reg))
                            && ({grow_h_reg, 1'b0} <= (COORD_W+1)'(max_size_reg));
        status.out_free   = out_free;
    end

    // Table writes: a fill update on the chosen row or a freshly opened row.
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = best_idx_reg;
        wr_entry.top    = best_top_reg;
        wr_entry.height = best_h_reg;
        wr_entry.fill   = best_fill_reg + (COORD_W)'(req_w_reg);
        if (cmd.op == OP_PLACE) begin
            ram_we = 1'b1;
        end else if (cmd.op == OP_NEW_ROW) begin
            ram_we          = 1'b1;
            ram_waddr       = count_reg[IDX_W-1:0];
            wr_entry.top    = next_top_reg;
            wr_entry.height = row_h_reg;
            wr_entry.fill   = (COORD_W)'(req_w_reg);
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_size_reg  <= MAX_SIZE_RESET;
            count_reg     <= '0;
            next_top_reg  <= (COORD_W)'(FIRST_TOP_RESET);
            atlas_w_reg   <= ATLAS_START;
            atlas_h_reg   <= ATLAS_START;
            scan_idx_reg  <= '0;
            rd_vld_reg    <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_idx)
                    CFG_MAX_SIZE: begin
                        max_size_reg <= cfg_wdata;
                    end
                    CFG_FIRST_TOP: begin
                        if (count_reg == '0) begin
                            next_top_reg <= (COORD_W)'(cfg_wdata[TOP_CFG_W-1:0]);
                        end
                    end
                    default: begin
                    end
                endcase
            end

            if (cmd.op == OP_EMIT) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end

            case (cmd.op)
                OP_LOAD: begin
                    scan_idx_reg <= '0;
                    rd_vld_reg   <= 1'b0;
                    found_reg    <= 1'b0;
                end
                OP_SCAN: begin
                    if (scan_idx_reg != count_reg) begin
                        scan_idx_reg <= scan_idx_reg + 1'b1;
                        rd_vld_reg   <= 1'b1;
                    end else begin
                        rd_vld_reg <= 1'b0;
                    end
                    if (candidate) found_reg <= 1'b1;
                end
                OP_NEW_ROW: begin
                    count_reg    <= count_reg + 1'b1;
                    next_top_reg <= row_end[COORD_W-1:0];
                    atlas_w_reg  <= grow_w_reg;
                    atlas_h_reg  <= grow_h_reg;
                end
                default: begin
                end
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_LOAD: begin
                req_w_reg <= in_w;
                req_h_reg <= in_h;
                prod_reg  <= DIV10_PROD_W'(in_h) * DIV10_PROD_W'(DIV10_MUL);
            end
            OP_SCAN: begin
                rd_idx_reg <= scan_idx_reg[IDX_W-1:0];
                if (candidate) begin
                    best_idx_reg  <= rd_idx_reg;
                    best_h_reg    <= rd_entry.height;
                    best_top_reg  <= rd_entry.top;
                    best_fill_reg <= rd_entry.fill;
                end
            end
            OP_PLACE: begin
                res_x_reg      <= best_fill_reg[RECT_W-1:0];
                res_y_reg      <= best_top_reg;
                res_status_reg <= STATUS_PLACED;
                res_aw_reg     <= atlas_w_reg;
                res_ah_reg     <= atlas_h_reg;
            end
            OP_FULL: begin
                res_x_reg      <= '0;
                res_y_reg      <= '0;
                res_status_reg <= STATUS_TABLE_FULL;
                res_aw_reg     <= atlas_w_reg;
                res_ah_reg     <= atlas_h_reg;
            end
            OP_GROW_INIT: begin
                row_h_reg  <= row_h_calc;
                grow_w_reg <= atlas_w_reg;
                grow_h_reg <= atlas_h_reg;
            end
            OP_DOUBLE: begin
                grow_w_reg <= {grow_w_reg[COORD_W-2:0], 1'b0};
                grow_h_reg <= {grow_h_reg[COORD_W-2:0], 1'b0};
            end
            OP_NEW_ROW: begin
                res_x_reg      <= '0;
                res_y_reg      <= next_top_reg;
                res_status_reg <= STATUS_PLACED;
                res_aw_reg     <= grow_w_reg;
                res_ah_reg     <= grow_h_reg;
            end
            OP_FAIL: begin
                res_x_reg      <= '0;
                res_y_reg      <= '0;
                res_status_reg <= STATUS_NO_GROW;
                res_aw_reg     <= atlas_w_reg;
                res_ah_reg     <= atlas_h_reg;
            end
            OP_EMIT: begin
                out_x_reg      <= res_x_reg;
                out_y_reg      <= res_y_reg;
                out_status_reg <= res_status_reg;
                out_aw_reg     <= res_aw_reg;
                out_ah_reg     <= res_ah_reg;
            end
            default: begin
            end
        endcase
    end

    assign out_valid  = out_valid_reg;
    assign out_x      = out_x_reg;
    assign out_y      = out_y_reg;
    assign out_status = out_status_reg;
    assign out_aw     = out_aw_reg;
    assign out_ah     = out_ah_reg;

endmodule

`default_nettype wire

@@ design/shelf_atlas_packer_unit.sv @@
// Top level of the shelf atlas packer: stream ports, configuration port,
// controller and datapath. Depends on sap_pkg, sap_ctrl, sap_dp and sap_ram.
//
//   Channel | Direction | Handshake            | Payload
//   s_      | in        | s_tvalid / s_tready  | s_tdata: rect_width, rect_height
//   m_      | out       | m_tvalid / m_tready  | m_tdata: position, atlas size; m_tuser: status
//   cfg_    | in        | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// A request scans every stored row. When it lands on a stored row or finds the table full,
// it goes straight to the result step; otherwise the growth step doubles the atlas as often
// as needed, then opens a row or, when it cannot grow, reports that instead.
// The row scan reads one shelf entry per cycle from the table RAM. The result step waits
// while the output register holds a transaction not yet taken; a new request is taken once
// the result has moved there. aresetn is synchronous; cfg_ready is always high.
`default_nettype none

module shelf_atlas_packer_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [13:0] rect_width, [27:14] rect_height, [31:28] zero
    input  wire logic [31:0] s_tdata,

    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [13:0] pos_x, [28:14] pos_y, [43:29] atlas_width, [58:44] atlas_height,
    // [63:59] zero
    output logic      [63:0] m_tdata,
    // [1:0] status
    output logic      [1:0]  m_tuser,

    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [sap_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [sap_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import sap_pkg::*;

    sap_cmd_t           cmd;
    sap_status_t        status;
    logic [RECT_W-1:0]  out_x;
    logic [COORD_W-1:0] out_y;
    status_t            out_status;
    logic [COORD_W-1:0] out_aw;
    logic [COORD_W-1:0] out_ah;

    sap_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .status   (status),
        .cmd      (cmd)
    );

    sap_dp u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .status     (status),
        .in_w       (s_tdata[RECT_W-1:0]),
        .in_h       (s_tdata[2*RECT_W-1:RECT_W]),
        .cfg_we     (cfg_valid),
        .cfg_idx    (cfg_index),
        .cfg_wdata  (cfg_data),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .out_x      (out_x),
        .out_y      (out_y),
        .out_status (out_status),
        .out_aw     (out_aw),
        .out_ah     (out_ah)
    );

    assign s_tready  = cmd.in_ready;
    assign cfg_ready = 1'b1;
    assign m_tdata   = {5'b0, out_ah, out_aw, out_y, out_x};
    assign m_tuser   = out_status;

endmodule

`default_nettype wire
